FILE: sv/verm_pkg.sv
// Shared types, constants and table functions of the vehicle energy rate model.
package verm_pkg;

    localparam int REGEN_TABLE_BITS = 8;
    localparam int REGEN_SIZE = 2 ** REGEN_TABLE_BITS;
    localparam int REGEN_W = 17;

    // Powertrain classes.
    localparam logic [2:0] CLASS_ICE  = 3'd0;
    localparam logic [2:0] CLASS_BEV  = 3'd1;
    localparam logic [2:0] CLASS_PHEV = 3'd2;
    localparam logic [2:0] CLASS_FCEV = 3'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_HYBRID_LIMIT = 3'd0;
    localparam logic [2:0] REG_FC_LOW       = 3'd1;
    localparam logic [2:0] REG_FC_HIGH      = 3'd2;
    localparam logic [2:0] REG_FC_SPEED     = 3'd3;
    localparam logic [2:0] REG_FC_SHARE     = 3'd4;
    localparam logic [2:0] REG_FC_EFF       = 3'd5;
    localparam logic [2:0] REG_AUX_POWER    = 3'd6;
    localparam logic [2:0] REG_IDLE_POWER   = 3'd7;

    localparam logic [19:0] RST_HYBRID_LIMIT = 20'd113664;
    localparam logic [19:0] RST_FC_LOW       = 20'd2560;
    localparam logic [19:0] RST_FC_HIGH      = 20'd5120;
    localparam logic [13:0] RST_FC_SPEED     = 14'd2276;
    localparam logic [15:0] RST_FC_SHARE     = 16'd13107;
    localparam logic [15:0] RST_FC_EFF       = 16'd60948;
    localparam logic [19:0] RST_AUX_POWER    = 20'd1024;
    localparam logic [19:0] RST_IDLE_POWER   = 20'd512;

    localparam logic [16:0] DRIVE_GAIN = 17'd78280;
    localparam longint unsigned ETA_COEF = 64'd11297481975;
    localparam longint unsigned Q30_ONE = 64'd1073741824;

    // Wheel power divisors are 2^17 times an odd factor.
    localparam longint ICE_DIV = 15073280;
    localparam longint WHEEL_DIV = 16384000;
    localparam longint ICE_ODD = ICE_DIV / 131072;
    localparam longint WHEEL_ODD = WHEEL_DIV / 131072;
    localparam logic [23:0] ICE_HALF = 24'(ICE_DIV / 2);
    localparam logic [23:0] WHEEL_HALF = 24'(WHEEL_DIV / 2);
    localparam logic [30:0] ICE_OFFSET = 31'(ICE_ODD * 8388608);
    localparam logic [30:0] WHEEL_OFFSET = 31'(WHEEL_ODD * 8388608);
    localparam logic [31:0] ICE_RECIP = 32'((64'd274877906944 + ICE_ODD - 1) / ICE_ODD);
    localparam logic [31:0] WHEEL_RECIP = 32'((64'd274877906944 + WHEEL_ODD - 1) / WHEEL_ODD);
    localparam logic [24:0] PW_BIAS = 25'd8388608;

    localparam logic [22:0] FUEL_P_MAX = 23'd4194304;
    localparam logic [27:0] FUEL_MAX = 28'd268435455;
    localparam logic signed [28:0] PWR_MAX = 29'sd1048575;
    localparam logic signed [28:0] PWR_MIN = -29'sd1048576;

    typedef struct packed {
        logic [18:0] inertia;
        logic [16:0] slope;
        logic [23:0] roll0;
        logic [9:0]  roll1;
        logic [14:0] aero;
    } body_t;

    typedef struct packed {
        logic [19:0] k0;
        logic [29:0] k1;
        logic [14:0] k2;
    } curve_t;

    typedef logic [REGEN_W-1:0] regen_tab_t [REGEN_SIZE];

    function automatic body_t body_of(logic [2:0] cls);
        body_t b;
        case (cls)
            CLASS_BEV:  b = '{19'd389376, 17'd59663, 24'd7826305, 10'd789, 15'd26219};
            CLASS_PHEV: b = '{19'd476160, 17'd72961, 24'd9570629, 10'd965, 15'd25449};
            CLASS_FCEV: b = '{19'd493568, 17'd75628, 24'd9920523, 10'd1000, 15'd26219};
            default:    b = '{19'd386847, 17'd56996, 24'd7476411, 10'd754, 15'd27655};
        endcase
        return b;
    endfunction

    function automatic curve_t curve_of(logic [2:0] cls);
        curve_t c;
        if (cls == CLASS_PHEV)
            c = '{20'd399587, 30'd597483977, 15'd18154};
        else
            c = '{20'd671883, 30'd793937184, 15'd18154};
        return c;
    endfunction

    // Braking weight exp(-0.0411/|acc|) at the center of table bin i.
    function automatic logic [REGEN_W-1:0] regen_entry(int i);
        longint unsigned z;
        longint unsigned t;
        z = (ETA_COEF * longint'(2 * i + 1)) >> (REGEN_TABLE_BITS + 8);
        t = Q30_ONE - z / 5;
        t = Q30_ONE - ((z * t) >> 30) / 4;
        t = Q30_ONE - ((z * t) >> 30) / 3;
        t = Q30_ONE - ((z * t) >> 30) / 2;
        t = Q30_ONE - ((z * t) >> 30);
        for (int k = 0; k < 6; k++)
            t = (t * t + 64'd536870912) >> 30;
        return REGEN_W'((t + 64'd8192) >> 14);
    endfunction

    // Weight indexed directly by braking magnitude below the table size.
    function automatic regen_tab_t regen_by_mag();
        regen_tab_t tab;
        longint q;
        longint n;
        longint idx;
        n = 2 * longint'(REGEN_SIZE);
        q = n;
        tab[0] = '0;
        for (int m = 1; m < REGEN_SIZE; m++) begin
            while (q * m > n)
                q = q - 1;
            idx = (q > REGEN_SIZE - 1) ? longint'(REGEN_SIZE - 1) : q;
            tab[m] = regen_entry(int'(idx));
        end
        return tab;
    endfunction

    localparam regen_tab_t REGEN_BY_MAG = regen_by_mag();
    localparam logic [REGEN_W-1:0] REGEN_BIN0 = regen_entry(0);
    localparam logic [REGEN_W-1:0] REGEN_BIN1 = regen_entry(1);
    localparam logic [REGEN_W-1:0] REGEN_BIN2 = regen_entry(2);

    typedef struct packed {
        logic [2:0]         cls;
        logic [13:0]        v;
        logic               acneg;
        logic [REGEN_W-1:0] regen;
    } tag_t;

endpackage

FILE: sv/vehicle_energy_rate_model.sv
// Vehicle energy rate model: fourteen-stage pipeline from one sample to fuel rate and power.
//
//   channel   direction  handshake                   payload
//   sample    in         sample_valid/sample_stall   func, speed, grade, accel
//   result    out        result_valid/result_stall   fuel_rate, power_kw
//   cfg       in         cfg_we                      cfg_index, cfg_data
//
// One sample enters every cycle unless a stalled result holds the pipeline; its result
// passes the stages in order (force sum, wheel power division, drivetrain products, fuel curve).
// Reset clears the valid bits and loads the configuration defaults.
// A stalled result freezes the whole pipeline, so sample_stall follows it at once.
module vehicle_energy_rate_model
    import verm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic [2:0]         func,
    input  logic [13:0]        speed,
    input  logic signed [13:0] grade,
    input  logic signed [12:0] accel,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [27:0]        fuel_rate,
    output logic signed [20:0] power_kw,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data
);

    logic [19:0] hybrid_limit_reg;
    logic [19:0] fc_low_reg;
    logic [19:0] fc_high_reg;
    logic [13:0] fc_speed_reg;
    logic [15:0] fc_share_reg;
    logic [15:0] fc_eff_reg;
    logic [19:0] aux_power_reg;
    logic [19:0] idle_power_reg;

    logic [14:1] vld_reg;
    logic        en;

    assign en = !(vld_reg[14] && result_stall);
    assign sample_stall = !en;
    assign result_valid = vld_reg[14];

    tag_t tag_reg [1:7];
    tag_t tag_next;

    // Stage 1: class constants and first products.
    body_t              bd1;
    logic [13:0]        mag;
    logic signed [32:0] in_x, ac_x;
    logic signed [31:0] sl_x, gr_x;
    logic signed [32:0] pin1_next, pin1_reg;
    logic signed [31:0] psl1_next, psl1_reg;
    logic [23:0]        pr1_next, pr1_reg;
    logic [27:0]        vv1_next, vv1_reg;

    always_comb
    begin
        bd1 = body_of(func);
        mag = 14'd0 - 14'(accel);
        tag_next.cls = func;
        tag_next.v = speed;
        tag_next.acneg = accel[12];
        if (mag < 14'(REGEN_SIZE))
            tag_next.regen = REGEN_BY_MAG[mag[REGEN_TABLE_BITS-1:0]];
        else if (mag == 14'(REGEN_SIZE))
            tag_next.regen = REGEN_BIN2;
        else if (mag <= 14'(2 * REGEN_SIZE))
            tag_next.regen = REGEN_BIN1;
        else
            tag_next.regen = REGEN_BIN0;
        in_x = 33'(bd1.inertia);
        ac_x = 33'(accel);
        sl_x = 32'(bd1.slope);
        gr_x = 32'(grade);
        pin1_next = in_x * ac_x;
        psl1_next = sl_x * gr_x;
        pr1_next = 24'(bd1.roll1) * 24'(speed);
        vv1_next = 28'(speed) * 28'(speed);
    end

    // Stage 2: aerodynamic term and partial sums.
    body_t              bd2;
    logic [42:0]        aw;
    logic signed [33:0] suma2_next, suma2_reg;
    logic [24:0]        sumb2_next, sumb2_reg;
    logic [26:0]        aer2_next, aer2_reg;

    always_comb
    begin
        bd2 = body_of(tag_reg[1].cls);
        aw = 43'(bd2.aero) * 43'(vv1_reg);
        aer2_next = aw[42:16];
        suma2_next = 34'(pin1_reg) + 34'(psl1_reg);
        sumb2_next = 25'(bd2.roll0) + 25'(pr1_reg);
    end

    // Stage 3: tractive force. Stage 4: force times speed.
    logic signed [34:0] frc3_next, frc3_reg;
    logic signed [49:0] fv4_next, fv4_reg;

    assign frc3_next = 35'(suma2_reg) + 35'(sumb2_reg) + 35'(aer2_reg);
    assign fv4_next = 50'(frc3_reg) * 50'(tag_reg[3].v);

    // Stage 5: round, drop the power of two and bias positive for the odd divisor.
    logic               ice5;
    logic signed [49:0] y5;
    logic signed [32:0] s5;
    logic signed [33:0] us5;
    logic [30:0]        u5_next, u5_reg;

    always_comb
    begin
        ice5 = (tag_reg[4].cls == CLASS_ICE);
        y5 = fv4_reg + 50'(ice5 ? ICE_HALF : WHEEL_HALF);
        s5 = y5[49:17];
        us5 = 34'(s5) + 34'(ice5 ? ICE_OFFSET : WHEEL_OFFSET);
        u5_next = us5[30:0];
    end

    // Stage 6: reciprocal product. Stage 7: quotient minus bias is the wheel power.
    logic [62:0]        pr6_next, pr6_reg;
    logic signed [24:0] pw7_next, pw7_reg;

    assign pr6_next = 63'(u5_reg) *
                      63'((tag_reg[5].cls == CLASS_ICE) ? ICE_RECIP : WHEEL_RECIP);
    assign pw7_next = 25'(pr6_reg[62:38]) - PW_BIAS;

    // Stage 8: drivetrain, regeneration and fuel cell products plus band tests.
    logic [16:0]        gain8;
    logic signed [24:0] low_x, high_x;
    logic signed [42:0] pa8_next, pa8_reg;
    logic signed [42:0] pb8_next, pb8_reg;
    logic               zr8_next, zr8_reg;
    logic               lo8_next, lo8_reg;
    logic               hi8_next, hi8_reg;
    logic               sp8_next, sp8_reg;
    logic [2:0]         cls8_reg;
    logic signed [24:0] pw8_reg;

    always_comb
    begin
        if (pw7_reg[24])
            gain8 = tag_reg[7].regen;
        else if (tag_reg[7].cls == CLASS_FCEV)
            gain8 = 17'(fc_eff_reg);
        else
            gain8 = DRIVE_GAIN;
        low_x = 25'(fc_low_reg);
        high_x = 25'(fc_high_reg);
        pa8_next = 43'(pw7_reg) * 43'(gain8);
        pb8_next = 43'(pw7_reg) * 43'(fc_share_reg);
        zr8_next = pw7_reg[24] && !tag_reg[7].acneg;
        lo8_next = pw7_reg <= low_x;
        hi8_next = pw7_reg <= high_x;
        sp8_next = tag_reg[7].v <= fc_speed_reg;
    end

    // Stage 9: products with the Q1.16 gains, rounded back to the power scale.
    logic signed [42:0] sa9, sb9;
    logic signed [26:0] ea9_next, ea9_reg;
    logic signed [26:0] eb9_next, eb9_reg;
    logic [2:0]         cls9_reg;
    logic signed [24:0] pw9_reg;
    logic               lo9_reg, hi9_reg, sp9_reg;

    always_comb
    begin
        sa9 = pa8_reg + 43'sd32768;
        sb9 = pb8_reg + 43'sd32768;
        ea9_next = zr8_reg ? 27'sd0 : sa9[42:16];
        eb9_next = sb9[42:16];
    end

    // Stage 10: per-class power split and fuel curve input.
    logic signed [28:0] ea_x, eb_x, pw_x, aux_x, idle_x;
    logic signed [27:0] lim_x, ea28, praw;
    logic [2:0]         cls10_reg;
    logic               fen10_next, fen10_reg;
    logic [22:0]        p10_next, p10_reg;
    logic signed [28:0] pwr10_next, pwr10_reg;

    always_comb
    begin
        ea_x = 29'(ea9_reg);
        eb_x = 29'(eb9_reg);
        pw_x = 29'(pw9_reg);
        aux_x = 29'(aux_power_reg);
        idle_x = 29'(idle_power_reg);
        lim_x = 28'(hybrid_limit_reg);
        ea28 = 28'(ea9_reg);
        praw = '0;
        fen10_next = 1'b0;
        pwr10_next = '0;
        case (cls9_reg)
            CLASS_ICE:
            begin
                fen10_next = 1'b1;
                praw = 28'(pw9_reg);
            end
            CLASS_BEV:
                pwr10_next = ea_x;
            CLASS_PHEV:
            begin
                if (ea28 > lim_x) begin
                    fen10_next = 1'b1;
                    praw = ea28 - lim_x;
                    pwr10_next = 29'(hybrid_limit_reg);
                end
                else begin
                    pwr10_next = ea_x;
                end
            end
            CLASS_FCEV:
            begin
                if (pw9_reg[24])
                    pwr10_next = ea_x;
                else if (lo9_reg || (hi9_reg && sp9_reg))
                    pwr10_next = pw_x + aux_x + idle_x;
                else if (hi9_reg)
                    pwr10_next = idle_x + aux_x + ea_x;
                else
                    pwr10_next = eb_x + aux_x + ea_x;
            end
            default:
                ;
        endcase
        if (praw[27])
            p10_next = '0;
        else if (praw > 28'(FUEL_P_MAX))
            p10_next = FUEL_P_MAX;
        else
            p10_next = praw[22:0];
    end

    // Stages 11 to 13: quadratic fuel curve, the square term in two halves.
    curve_t             cv11, cv12, cv13;
    logic [45:0]        p2_11_next, p2_11_reg;
    logic [52:0]        kp11_next, kp11_reg, kp12_reg;
    logic [37:0]        hi12_next, hi12_reg, lo12_next, lo12_reg;
    logic [60:0]        acc13;
    logic [36:0]        fq13_next, fq13_reg;
    logic [2:0]         cls11_reg, cls12_reg, cls13_reg, cls14_reg;
    logic               fen11_reg, fen12_reg, fen13_reg;
    logic signed [28:0] pwr11_reg, pwr12_reg, pwr13_reg;

    always_comb
    begin
        cv11 = curve_of(cls10_reg);
        cv12 = curve_of(cls11_reg);
        p2_11_next = 46'(p10_reg) * 46'(p10_reg);
        kp11_next = 53'(cv11.k1) * 53'(p10_reg);
        hi12_next = 38'(cv12.k2) * 38'(p2_11_reg[45:23]);
        lo12_next = 38'(cv12.k2) * 38'(p2_11_reg[22:0]);
        acc13 = 61'(kp12_reg) + {hi12_reg, 23'd0} + 61'(lo12_reg) + 61'd8388608;
        fq13_next = acc13[60:24];
    end

    // Stage 14: idle term and saturation into the result word.
    logic [37:0]        fsum;
    logic [27:0]        fuel14_next, fuel14_reg;
    logic signed [20:0] pwr14_next, pwr14_reg;

    always_comb
    begin
        cv13 = curve_of(cls13_reg);
        fsum = 38'(cv13.k0) + 38'(fq13_reg);
        if (!fen13_reg)
            fuel14_next = '0;
        else if (fsum > 38'(FUEL_MAX))
            fuel14_next = FUEL_MAX;
        else
            fuel14_next = fsum[27:0];
        if (pwr13_reg > PWR_MAX)
            pwr14_next = PWR_MAX[20:0];
        else if (pwr13_reg < PWR_MIN)
            pwr14_next = PWR_MIN[20:0];
        else
            pwr14_next = pwr13_reg[20:0];
    end

    assign fuel_rate = fuel14_reg;
    assign power_kw = pwr14_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hybrid_limit_reg <= RST_HYBRID_LIMIT;
            fc_low_reg <= RST_FC_LOW;
            fc_high_reg <= RST_FC_HIGH;
            fc_speed_reg <= RST_FC_SPEED;
            fc_share_reg <= RST_FC_SHARE;
            fc_eff_reg <= RST_FC_EFF;
            aux_power_reg <= RST_AUX_POWER;
            idle_power_reg <= RST_IDLE_POWER;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                REG_HYBRID_LIMIT: hybrid_limit_reg <= cfg_data;
                REG_FC_LOW:       fc_low_reg <= cfg_data;
                REG_FC_HIGH:      fc_high_reg <= cfg_data;
                REG_FC_SPEED:     fc_speed_reg <= cfg_data[13:0];
                REG_FC_SHARE:     fc_share_reg <= cfg_data[15:0];
                REG_FC_EFF:       fc_eff_reg <= cfg_data[15:0];
                REG_AUX_POWER:    aux_power_reg <= cfg_data;
                REG_IDLE_POWER:   idle_power_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[13:1], sample_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            tag_reg[1] <= tag_next;
            for (int k = 2; k <= 7; k++)
                tag_reg[k] <= tag_reg[k-1];
            pin1_reg <= pin1_next;
            psl1_reg <= psl1_next;
            pr1_reg <= pr1_next;
            vv1_reg <= vv1_next;
            suma2_reg <= suma2_next;
            sumb2_reg <= sumb2_next;
            aer2_reg <= aer2_next;
            frc3_reg <= frc3_next;
            fv4_reg <= fv4_next;
            u5_reg <= u5_next;
            pr6_reg <= pr6_next;
            pw7_reg <= pw7_next;
            cls8_reg <= tag_reg[7].cls;
            pw8_reg <= pw7_reg;
            pa8_reg <= pa8_next;
            pb8_reg <= pb8_next;
            zr8_reg <= zr8_next;
            lo8_reg <= lo8_next;
            hi8_reg <= hi8_next;
            sp8_reg <= sp8_next;
            cls9_reg <= cls8_reg;
            pw9_reg <= pw8_reg;
            ea9_reg <= ea9_next;
            eb9_reg <= eb9_next;
            lo9_reg <= lo8_reg;
            hi9_reg <= hi8_reg;
            sp9_reg <= sp8_reg;
            cls10_reg <= cls9_reg;
            fen10_reg <= fen10_next;
            p10_reg <= p10_next;
            pwr10_reg <= pwr10_next;
            cls11_reg <= cls10_reg;
            fen11_reg <= fen10_reg;
            pwr11_reg <= pwr10_reg;
            p2_11_reg <= p2_11_next;
            kp11_reg <= kp11_next;
            cls12_reg <= cls11_reg;
            fen12_reg <= fen11_reg;
            pwr12_reg <= pwr11_reg;
            kp12_reg <= kp11_reg;
            hi12_reg <= hi12_next;
            lo12_reg <= lo12_next;
            cls13_reg <= cls12_reg;
            fen13_reg <= fen12_reg;
            pwr13_reg <= pwr12_reg;
            fq13_reg <= fq13_next;
            cls14_reg <= cls13_reg;
            fuel14_reg <= fuel14_next;
            pwr14_reg <= pwr14_next;
        end
    end

    // A word in the last internal stage reaches the output when the pipeline moves.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[13] && en) |=> result_valid)
        else $error("pipeline lost a word before the output stage");

    // A hybrid that burns fuel runs its motor exactly at the cap.
    a_hybrid_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[10] && cls10_reg == CLASS_PHEV && fen10_reg)
        |-> pwr10_reg == 29'(hybrid_limit_reg))
        else $error("hybrid motor power differs from its cap while fuel is used");

    a_ice_power: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && cls14_reg == CLASS_ICE) |-> power_kw == 21'sd0)
        else $error("combustion result carries electric power");

    a_electric_fuel: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (cls14_reg == CLASS_BEV || cls14_reg == CLASS_FCEV))
        |-> fuel_rate == 28'd0)
        else $error("battery or fuel cell result carries a fuel rate");

endmodule
